>>> hdl/qsdps_pkg.sv
package qsdps_pkg;

    // Default sizes handed to the top level parameters.
    localparam int DEF_POS_WIDTH      = 32;
    localparam int DEF_GAIN_FRAC_BITS = 8;

    // Fixed field widths.
    localparam int OP_W        = 3;
    localparam int SETPOINT_W  = 32;
    localparam int ERROR_W     = 32;
    localparam int DUTY_W      = 8;
    localparam int GAIN_W      = 16;
    localparam int STEP_W      = 8;
    localparam int INTEG_W     = 9;
    localparam int BLINK_W     = 7;
    localparam int IN_DATA_W   = 40;
    localparam int OUT_DATA_W  = 48;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Widest position is 64 bits; products carry a 17-bit signed gain,
    // and the three-term sum needs two more bits of headroom.
    localparam int SUM_MAX_W = 64 + GAIN_W + 3;

    // Drive and integrator limit, LED blink lengths in ticks.
    localparam int OUT_LIMIT     = 253;
    localparam int OVERRUN_BLINK = 50;
    localparam int START_BLINK   = 100;

    // Register reset values.
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 16'd5120;
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 16'd102;
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 16'd12800;
    localparam logic [STEP_W-1:0] STEP_INC_RST   = 8'd2;

    localparam logic signed [SUM_MAX_W-1:0] LIM_POS = SUM_MAX_W'(OUT_LIMIT);
    localparam logic signed [SUM_MAX_W-1:0] LIM_NEG = -SUM_MAX_W'(OUT_LIMIT);

    typedef enum logic [OP_W-1:0] {
        OP_ENC_SAMPLE = 3'd0,
        OP_STEP       = 3'd1,
        OP_TICK       = 3'd2,
        OP_LOAD       = 3'd3,
        OP_ALIGN      = 3'd4
    } op_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_STEP_INC   = 3'd3,
        REG_DIR_POL    = 3'd4
    } cfg_reg_t;

    // Flags that travel with a state snapshot into the drive pipeline.
    typedef struct packed {
        logic led_on;
        logic dir_polarity;
    } snap_flags_t;

    // Divide by 2^frac truncating toward zero, then clamp to the drive limit.
    function automatic logic signed [INTEG_W-1:0] scale_clamp(
        input logic signed [SUM_MAX_W-1:0] s,
        input int unsigned                 frac
    );
        logic signed [SUM_MAX_W-1:0] bias;
        logic signed [SUM_MAX_W-1:0] q;
        bias = s[SUM_MAX_W-1] ? ((SUM_MAX_W'(1) << frac) - SUM_MAX_W'(1)) : '0;
        q = (s + bias) >>> frac;
        if (q > LIM_POS)
            q = LIM_POS;
        else if (q < LIM_NEG)
            q = LIM_NEG;
        return q[INTEG_W-1:0];
    endfunction

endpackage

>>> hdl/qsdps_drive.sv
module qsdps_drive #(
    parameter int POS_WIDTH      = qsdps_pkg::DEF_POS_WIDTH,
    parameter int GAIN_FRAC_BITS = qsdps_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [POS_WIDTH-1:0]            err,
    input  logic signed [POS_WIDTH-1:0]            delta,
    input  logic signed [qsdps_pkg::INTEG_W-1:0]   integ,
    input  qsdps_pkg::snap_flags_t                 flags,
    input  logic [qsdps_pkg::GAIN_W-1:0]           prop_gain,
    input  logic [qsdps_pkg::GAIN_W-1:0]           deriv_gain,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [qsdps_pkg::DUTY_W-1:0]           out_duty,
    output logic                                   out_dir,
    output logic                                   out_led,
    output logic signed [qsdps_pkg::ERROR_W-1:0]   out_error
);
    import qsdps_pkg::*;

    localparam int PROD_W = POS_WIDTH + GAIN_W + 1;

    logic                          prod_valid_reg;
    logic signed [PROD_W-1:0]      prod_p_reg;
    logic signed [PROD_W-1:0]      prod_d_reg;
    logic signed [INTEG_W-1:0]     integ_reg;
    snap_flags_t                   flags_reg;
    logic signed [ERROR_W-1:0]     err_reg;

    logic                          res_valid_reg;
    logic [DUTY_W-1:0]             duty_reg;
    logic                          dir_reg;
    logic                          led_reg;
    logic signed [ERROR_W-1:0]     error_reg;

    logic                          res_free;
    logic                          prod_move;
    logic signed [GAIN_W:0]        prop_gain_s;
    logic signed [GAIN_W:0]        deriv_gain_s;
    logic signed [PROD_W-1:0]      prod_p_next;
    logic signed [PROD_W-1:0]      prod_d_next;
    logic signed [SUM_MAX_W-1:0]   sum;
    logic signed [INTEG_W-1:0]     drive;
    logic [INTEG_W-1:0]            drive_mag;

    // Handshake between the product stage and the result register.
    assign res_free  = !res_valid_reg || out_ready;
    assign prod_move = prod_valid_reg && res_free;
    assign in_ready  = !prod_valid_reg || res_free;

    // Proportional and derivative products.
    assign prop_gain_s  = $signed({1'b0, prop_gain});
    assign deriv_gain_s = $signed({1'b0, deriv_gain});
    assign prod_p_next  = PROD_W'(err) * PROD_W'(prop_gain_s);
    assign prod_d_next  = PROD_W'(delta) * PROD_W'(deriv_gain_s);

    // P + I - D, scaled and clamped; duty is the even part of the magnitude.
    assign sum = SUM_MAX_W'(prod_p_reg) + (SUM_MAX_W'(integ_reg) <<< GAIN_FRAC_BITS)
                 - SUM_MAX_W'(prod_d_reg);
    assign drive     = scale_clamp(sum, GAIN_FRAC_BITS);
    assign drive_mag = drive[INTEG_W-1] ? INTEG_W'(-drive) : INTEG_W'(drive);

    // Product stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            prod_p_reg <= prod_p_next;
            prod_d_reg <= prod_d_next;
            integ_reg  <= integ;
            flags_reg  <= flags;
            err_reg    <= ERROR_W'(err);
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_move)
        begin
            duty_reg  <= {drive_mag[DUTY_W-1:1], 1'b0};
            dir_reg   <= (drive > 0) ? flags_reg.dir_polarity : !flags_reg.dir_polarity;
            led_reg   <= flags_reg.led_on;
            error_reg <= err_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_duty  = duty_reg;
    assign out_dir   = dir_reg;
    assign out_led   = led_reg;
    assign out_error = error_reg;

endmodule

>>> hdl/quadrature_step_dir_pid_servo.sv
// Position servo with a quadrature decoder and a step/direction setpoint.
// Each input word (an encoder sample, a step pulse, a sample tick, a setpoint
// load or an align request, chosen by s_tuser) updates the loop state and
// yields exactly one output word: drive duty, direction pin, error LED and
// the position error, all taken from the state after that update. The block
// takes one word per clock while the output is not held. An output word is
// valid once its input word has passed four registers: input register,
// state update (including the integrator step on a tick), the proportional
// and derivative multipliers, then the sum, scale and clamp into the output
// register. Backpressure on the output holds only the stages that are full.
// Both encoder channels changing at once is an overrun: the count is kept
// and the LED lights for 50 ticks. Configuration writes are always taken
// and must only be issued while no word is in flight.
module quadrature_step_dir_pid_servo #(
    parameter int POS_WIDTH      = qsdps_pkg::DEF_POS_WIDTH,
    parameter int GAIN_FRAC_BITS = qsdps_pkg::DEF_GAIN_FRAC_BITS
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // [0] enc_a, [1] enc_b, [2] step_forward, [34:3] new_setpoint, rest zero
    input  logic [qsdps_pkg::IN_DATA_W-1:0]      s_tdata,
    // [2:0] operation
    input  logic [qsdps_pkg::OP_W-1:0]           s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [7:0] drive_duty, [8] drive_dir, [9] error_led, [41:10] position_error
    output logic [qsdps_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [qsdps_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [qsdps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import qsdps_pkg::*;

    localparam int PROD_W = POS_WIDTH + GAIN_W + 1;

    // Configuration registers.
    logic [GAIN_W-1:0]              prop_gain_reg;
    logic [GAIN_W-1:0]              integ_gain_reg;
    logic [GAIN_W-1:0]              deriv_gain_reg;
    logic [STEP_W-1:0]              step_inc_reg;
    logic                           dir_pol_reg;

    // Input register.
    logic                           in_valid_reg;
    op_t                            in_op_reg;
    logic                           in_enc_a_reg;
    logic                           in_enc_b_reg;
    logic                           in_fwd_reg;
    logic signed [SETPOINT_W-1:0]   in_setpoint_reg;

    // Loop state.
    logic                           state_valid_reg;
    logic signed [POS_WIDTH-1:0]    target_reg,  target_next;
    logic signed [POS_WIDTH-1:0]    actual_reg,  actual_next;
    logic signed [POS_WIDTH-1:0]    last_reg,    last_next;
    logic signed [POS_WIDTH-1:0]    delta_reg,   delta_next;
    logic [1:0]                     prev_ab_reg, prev_ab_next;
    logic signed [INTEG_W-1:0]      integ_reg,   integ_next;
    logic [BLINK_W-1:0]             blink_reg,   blink_next;
    logic                           led_reg,     led_next;

    logic                           drive_ready;
    logic                           state_free;
    logic                           state_load;
    logic [1:0]                     ab_now;
    logic [1:0]                     ab_diff;
    logic                           count_up;
    logic signed [POS_WIDTH-1:0]    err_cur;
    logic signed [GAIN_W:0]         integ_gain_s;
    logic signed [PROD_W-1:0]       integ_prod;
    logic signed [SUM_MAX_W-1:0]    integ_sum;
    logic signed [INTEG_W-1:0]      integ_step;
    snap_flags_t                    snap_flags;

    logic                           res_valid;
    logic [DUTY_W-1:0]              res_duty;
    logic                           res_dir;
    logic                           res_led;
    logic signed [ERROR_W-1:0]      res_error;

    // Configuration writes, masked to each register's width; a zero step increment is ignored.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg  <= PROP_GAIN_RST;
            integ_gain_reg <= INTEG_GAIN_RST;
            deriv_gain_reg <= DERIV_GAIN_RST;
            step_inc_reg   <= STEP_INC_RST;
            dir_pol_reg    <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROP_GAIN:  prop_gain_reg  <= cfg_data;
                REG_INTEG_GAIN: integ_gain_reg <= cfg_data;
                REG_DERIV_GAIN: deriv_gain_reg <= cfg_data;
                REG_STEP_INC:
                begin
                    if (cfg_data[STEP_W-1:0] != '0)
                        step_inc_reg <= cfg_data[STEP_W-1:0];
                end
                REG_DIR_POL:    dir_pol_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Pipeline handshake: a stage moves on when the next one is empty or moving.
    assign state_free = !state_valid_reg || drive_ready;
    assign state_load = in_valid_reg && state_free;
    assign s_tready   = !in_valid_reg || state_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg       <= op_t'(s_tuser);
            in_enc_a_reg    <= s_tdata[0];
            in_enc_b_reg    <= s_tdata[1];
            in_fwd_reg      <= s_tdata[2];
            in_setpoint_reg <= $signed(s_tdata[34:3]);
        end
    end

    // Quadrature decode of the new encoder levels.
    assign ab_now   = {in_enc_b_reg, in_enc_a_reg};
    assign ab_diff  = ab_now ^ prev_ab_reg;
    assign count_up = (ab_diff == 2'b01) ? (in_enc_a_reg == in_enc_b_reg)
                                         : (in_enc_a_reg != in_enc_b_reg);

    // Integrator step: (integ * 2^F + ki * err) / 2^F, clamped.
    assign err_cur      = target_reg - actual_reg;
    assign integ_gain_s = $signed({1'b0, integ_gain_reg});
    assign integ_prod   = PROD_W'(err_cur) * PROD_W'(integ_gain_s);
    assign integ_sum    = SUM_MAX_W'(integ_prod)
                          + (SUM_MAX_W'(integ_reg) <<< GAIN_FRAC_BITS);
    assign integ_step   = scale_clamp(integ_sum, GAIN_FRAC_BITS);

    // Next loop state for the word in the input register.
    always_comb
    begin
        target_next  = target_reg;
        actual_next  = actual_reg;
        last_next    = last_reg;
        delta_next   = delta_reg;
        prev_ab_next = prev_ab_reg;
        integ_next   = integ_reg;
        blink_next   = blink_reg;
        led_next     = led_reg;
        if (state_load)
        begin
            case (in_op_reg)
                OP_ENC_SAMPLE:
                begin
                    prev_ab_next = ab_now;
                    if (ab_diff == 2'b11)
                    begin
                        led_next   = 1'b1;
                        blink_next = BLINK_W'(OVERRUN_BLINK);
                    end
                    else if (ab_diff != 2'b00)
                    begin
                        actual_next = count_up ? actual_reg + POS_WIDTH'(1)
                                               : actual_reg - POS_WIDTH'(1);
                    end
                end
                OP_STEP:
                begin
                    target_next = in_fwd_reg ? target_reg + POS_WIDTH'(step_inc_reg)
                                             : target_reg - POS_WIDTH'(step_inc_reg);
                end
                OP_TICK:
                begin
                    if (blink_reg != '0)
                        blink_next = blink_reg - BLINK_W'(1);
                    delta_next = actual_reg - last_reg;
                    last_next  = actual_reg;
                    integ_next = integ_step;
                end
                OP_LOAD:  target_next = POS_WIDTH'(in_setpoint_reg);
                OP_ALIGN: actual_next = target_reg;
                default: ;
            endcase
            // The LED goes dark once the blink timer has run out.
            if (blink_next == '0)
                led_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_valid_reg <= 1'b0;
            target_reg      <= '0;
            actual_reg      <= '0;
            last_reg        <= '0;
            delta_reg       <= '0;
            prev_ab_reg     <= '0;
            integ_reg       <= '0;
            blink_reg       <= BLINK_W'(START_BLINK);
            led_reg         <= 1'b1;
        end
        else
        begin
            if (state_free)
                state_valid_reg <= in_valid_reg;
            target_reg  <= target_next;
            actual_reg  <= actual_next;
            last_reg    <= last_next;
            delta_reg   <= delta_next;
            prev_ab_reg <= prev_ab_next;
            integ_reg   <= integ_next;
            blink_reg   <= blink_next;
            led_reg     <= led_next;
        end
    end

    // Drive law on the state snapshot.
    assign snap_flags.led_on       = led_reg;
    assign snap_flags.dir_polarity = dir_pol_reg;

    qsdps_drive #(
        .POS_WIDTH      (POS_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_drive (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (state_valid_reg),
        .in_ready   (drive_ready),
        .err        (err_cur),
        .delta      (delta_reg),
        .integ      (integ_reg),
        .flags      (snap_flags),
        .prop_gain  (prop_gain_reg),
        .deriv_gain (deriv_gain_reg),
        .out_valid  (res_valid),
        .out_ready  (m_tready),
        .out_duty   (res_duty),
        .out_dir    (res_dir),
        .out_led    (res_led),
        .out_error  (res_error)
    );

    assign m_tvalid = res_valid;
    assign m_tdata  = {6'b0, res_error, res_led, res_dir, res_duty};

    // The LED is never lit with the blink timer at zero.
    a_led_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (blink_reg == '0) |-> !led_reg)
        else $error("error LED lit with blink timer expired");

    // The integrator stays inside the drive limit.
    a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= INTEG_W'(OUT_LIMIT)) && (integ_reg >= -INTEG_W'(OUT_LIMIT)))
        else $error("integrator outside its clamp");

    // A word held in the input register is not dropped while the state stage stalls.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !state_free) |=> (in_valid_reg && $stable(in_op_reg)))
        else $error("stalled input word lost");

endmodule
